// ===== hw/rtl/hss_pkg.sv =====
// Package for the heater safety supervisor: command, fault and register codes,
// reset values, fixed thresholds and the structs passed between the modules.
// No dependencies.
`timescale 1ns / 1ps

package hss_pkg;

   // Configuration port geometry: eight 32-bit registers at byte addresses 4*i.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Command codes of an input item.
   localparam logic [2:0] CMD_SAMPLE     = 3'd0;
   localparam logic [2:0] CMD_SET_TARGET = 3'd1;
   localparam logic [2:0] CMD_PAUSE      = 3'd2;
   localparam logic [2:0] CMD_RESUME     = 3'd3;
   localparam logic [2:0] CMD_DISABLE    = 3'd4;
   localparam logic [2:0] CMD_ENABLE     = 3'd5;
   localparam logic [2:0] CMD_RESET      = 3'd6;

   // Fault reason codes.
   localparam logic [1:0] FAIL_NONE        = 2'd0;
   localparam logic [1:0] FAIL_CUTOFF      = 2'd1;
   localparam logic [1:0] FAIL_NOT_HEATING = 2'd2;
   localparam logic [1:0] FAIL_DROPPING    = 2'd3;

   // Register indexes.
   localparam logic [2:0] REG_MAX_TARGET    = 3'd0;
   localparam logic [2:0] REG_TIMING_EN     = 3'd1;
   localparam logic [2:0] REG_CUTOFF_TEMP   = 3'd2;
   localparam logic [2:0] REG_MAX_BAD       = 3'd3;
   localparam logic [2:0] REG_BYPASS_DELTA  = 3'd4;
   localparam logic [2:0] REG_PROGRESS_TIME = 3'd5;
   localparam logic [2:0] REG_WARMUP_TIME   = 3'd6;
   localparam logic [2:0] REG_REACH_HYST    = 3'd7;

   // Register reset values.
   localparam logic [9:0]  RST_MAX_TARGET    = 10'd280;
   localparam logic        RST_TIMING_EN     = 1'b1;
   localparam logic [9:0]  RST_CUTOFF_TEMP   = 10'd290;
   localparam logic [7:0]  RST_MAX_BAD       = 8'd15;
   localparam logic [7:0]  RST_BYPASS_DELTA  = 8'd10;
   localparam logic [23:0] RST_PROGRESS_TIME = 24'd90000;
   localparam logic [23:0] RST_WARMUP_TIME   = 24'd300000;
   localparam logic [4:0]  RST_REACH_HYST    = 5'd2;

   // Fixed thresholds, in degrees unless noted.
   localparam logic signed [12:0] BAD_READING_LIMIT = 13'sd290;
   localparam logic signed [12:0] DROP_MARGIN       = 13'sd30;
   localparam logic signed [12:0] CHECKED_LIMIT     = 13'sd50;
   localparam logic signed [12:0] PROGRESS_STEP     = 13'sd10;
   localparam logic signed [12:0] BYPASS_BAND       = 13'sd10;
   localparam logic [9:0]         TIMING_MIN_TARGET = 10'd30;
   localparam logic [7:0]         POWER_FULL        = 8'd255;
   localparam logic [7:0]         RUN_COUNT_MAX     = 8'd255;

   typedef struct packed {
      logic [9:0]  max_target;
      logic        timing_check_enable;
      logic [9:0]  cutoff_temp;
      logic [7:0]  max_bad_readings;
      logic [7:0]  bypass_delta;
      logic [23:0] progress_time_ms;
      logic [23:0] warmup_time_ms;
      logic [4:0]  reach_hysteresis;
   } hss_cfg_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [10:0] temperature;
      logic [15:0] pid_drive;
      logic [15:0] elapsed_ms;
      logic [15:0] new_target;
   } hss_req_type;

   typedef struct packed {
      logic [7:0] heater_power;
      logic       bypass_active;
      logic       pid_clear;
      logic       failed;
      logic [1:0] fail_reason;
      logic       target_reached;
      logic [9:0] active_target;
      logic       paused_flag;
      logic       disabled_flag;
   } hss_rsp_type;

   typedef struct packed {
      logic [10:0] current_reading;
      logic [10:0] start_reading;
      logic [9:0]  saved_target;
      logic [9:0]  target_value;
      logic [7:0]  bad_run_count;
      logic        fault_latched;
      logic [1:0]  fault_code;
      logic        bypass_on;
      logic [23:0] heatup_remaining;
      logic        heatup_armed;
      logic [23:0] progress_remaining;
      logic        progress_armed;
      logic        progress_done;
      logic        reached_latch;
      logic        pause_on;
      logic        disable_on;
      logic [7:0]  last_power;
      logic        pid_pulse;
   } hss_state_type;

endpackage

// ===== hw/rtl/hss_channels.sv =====
// Valid/ready channel interfaces for the heater safety supervisor:
// the request channel (commands and samples) and the response channel (status).
// No dependencies.
`timescale 1ns / 1ps

interface hss_req_if;
   logic               valid;
   logic               ready;
   logic        [2:0]  cmd;
   logic signed [10:0] temperature;
   logic signed [15:0] pid_drive;
   logic        [15:0] elapsed_ms;
   logic signed [15:0] new_target;

   modport source (output valid, cmd, temperature, pid_drive, elapsed_ms, new_target,
                   input ready);
   modport sink (input valid, cmd, temperature, pid_drive, elapsed_ms, new_target,
                 output ready);
endinterface

interface hss_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] heater_power;
   logic       bypass_active;
   logic       pid_clear;
   logic       failed;
   logic [1:0] fail_reason;
   logic       target_reached;
   logic [9:0] active_target;
   logic       paused_flag;
   logic       disabled_flag;

   modport source (output valid, heater_power, bypass_active, pid_clear, failed,
                   fail_reason, target_reached, active_target, paused_flag,
                   disabled_flag, input ready);
   modport sink (input valid, heater_power, bypass_active, pid_clear, failed,
                 fail_reason, target_reached, active_target, paused_flag,
                 disabled_flag, output ready);
endinterface

// ===== hw/rtl/hss_csr.sv =====
// Configuration registers of the heater safety supervisor behind an APB-style port.
// Depends on hss_pkg.
`timescale 1ns / 1ps

module hss_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [hss_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [hss_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [hss_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output hss_pkg::hss_cfg_type             cfg
);

   hss_pkg::hss_cfg_type cfg_ff;
   hss_pkg::hss_cfg_type cfg_in;
   logic [2:0]           reg_index;
   logic                 write_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign write_en  = psel && penable && pwrite;
   assign cfg       = cfg_ff;

   // Register write decode; a write completes in the access cycle.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            hss_pkg::REG_MAX_TARGET:    cfg_in.max_target          = pwdata[9:0];
            hss_pkg::REG_TIMING_EN:     cfg_in.timing_check_enable = pwdata[0];
            hss_pkg::REG_CUTOFF_TEMP:   cfg_in.cutoff_temp         = pwdata[9:0];
            hss_pkg::REG_MAX_BAD:       cfg_in.max_bad_readings    = pwdata[7:0];
            hss_pkg::REG_BYPASS_DELTA:  cfg_in.bypass_delta        = pwdata[7:0];
            hss_pkg::REG_PROGRESS_TIME: cfg_in.progress_time_ms    = pwdata[23:0];
            hss_pkg::REG_WARMUP_TIME:   cfg_in.warmup_time_ms      = pwdata[23:0];
            hss_pkg::REG_REACH_HYST:    cfg_in.reach_hysteresis    = pwdata[4:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_target          <= hss_pkg::RST_MAX_TARGET;
         cfg_ff.timing_check_enable <= hss_pkg::RST_TIMING_EN;
         cfg_ff.cutoff_temp         <= hss_pkg::RST_CUTOFF_TEMP;
         cfg_ff.max_bad_readings    <= hss_pkg::RST_MAX_BAD;
         cfg_ff.bypass_delta        <= hss_pkg::RST_BYPASS_DELTA;
         cfg_ff.progress_time_ms    <= hss_pkg::RST_PROGRESS_TIME;
         cfg_ff.warmup_time_ms      <= hss_pkg::RST_WARMUP_TIME;
         cfg_ff.reach_hysteresis    <= hss_pkg::RST_REACH_HYST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back mux, zero-extended to the bus width.
   always_comb begin
      case (reg_index)
         hss_pkg::REG_MAX_TARGET:    prdata = 32'(cfg_ff.max_target);
         hss_pkg::REG_TIMING_EN:     prdata = 32'(cfg_ff.timing_check_enable);
         hss_pkg::REG_CUTOFF_TEMP:   prdata = 32'(cfg_ff.cutoff_temp);
         hss_pkg::REG_MAX_BAD:       prdata = 32'(cfg_ff.max_bad_readings);
         hss_pkg::REG_BYPASS_DELTA:  prdata = 32'(cfg_ff.bypass_delta);
         hss_pkg::REG_PROGRESS_TIME: prdata = 32'(cfg_ff.progress_time_ms);
         hss_pkg::REG_WARMUP_TIME:   prdata = 32'(cfg_ff.warmup_time_ms);
         hss_pkg::REG_REACH_HYST:    prdata = 32'(cfg_ff.reach_hysteresis);
         default:                    prdata = '0;
      endcase
   end

endmodule

// ===== hw/rtl/hss_core.sv =====
// Supervisor state registers and the combinational next-state logic that applies
// one command or sample to them. Depends on hss_pkg.
`timescale 1ns / 1ps

module hss_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  hss_pkg::hss_req_type item,
   input  hss_pkg::hss_cfg_type cfg,
   output hss_pkg::hss_rsp_type rsp
);

   hss_pkg::hss_state_type state_ff;
   hss_pkg::hss_state_type state_in;
   hss_pkg::hss_state_type step_state;

   // Sign-extend an 11-bit reading to the 13-bit compare width.
   function automatic logic signed [12:0] ext_reading(input logic [10:0] r);
      return $signed({{2{r[10]}}, r});
   endfunction

   // Zero-extend a 10-bit target to the 13-bit compare width.
   function automatic logic signed [12:0] ext_target(input logic [9:0] t);
      return $signed({3'b000, t});
   endfunction

   function automatic logic [23:0] count_down(input logic [23:0] r, input logic [15:0] d);
      logic [23:0] d_ext;
      d_ext = {8'd0, d};
      return (r > d_ext) ? (r - d_ext) : 24'd0;
   endfunction

   // Clamp and apply a new target; with timing checks enabled this rearms or clears the heat-up and progress timers.
   function automatic hss_pkg::hss_state_type set_target(input hss_pkg::hss_state_type s_in,
                                                          input hss_pkg::hss_cfg_type c,
                                                          input logic signed [15:0] t);
      hss_pkg::hss_state_type s;
      logic [9:0]             tc;
      logic signed [12:0]     cur;
      s   = s_in;
      cur = ext_reading(s.current_reading);
      if (t > $signed({6'd0, c.max_target})) begin
         tc = c.max_target;
      end else if (t[15]) begin
         tc = '0;
      end else begin
         tc = t[9:0];
      end
      // While paused the new target only lowers the hold target and is saved; a zero target ends the pause.
      if (s.pause_on) begin
         if (tc < s.target_value) s.target_value = tc;
         if (tc == '0) s.pause_on = 1'b0;
         s.saved_target = tc;
         return s;
      end
      s.reached_latch = 1'b0;
      if (s.fault_latched || s.disable_on) begin
         s.target_value = '0;
         return s;
      end
      if (c.timing_check_enable) begin
         s.start_reading = s.current_reading;
         s.progress_done = 1'b0;
         s.bad_run_count = '0;
         if (tc > hss_pkg::TIMING_MIN_TARGET) begin
            if ((ext_target(tc) > cur + hss_pkg::PROGRESS_STEP) &&
                (cur < hss_pkg::CHECKED_LIMIT)) begin
               s.progress_armed     = 1'b1;
               s.progress_remaining = c.progress_time_ms;
            end else begin
               s.progress_armed     = 1'b0;
               s.progress_remaining = '0;
            end
            s.heatup_armed     = 1'b1;
            s.heatup_remaining = c.warmup_time_ms;
         end else begin
            s.heatup_armed       = 1'b0;
            s.heatup_remaining   = '0;
            s.progress_armed     = 1'b0;
            s.progress_remaining = '0;
         end
      end
      s.target_value = tc;
      return s;
   endfunction

   // The reached query answers false while paused, disabled or at or over the limit.
   function automatic logic reach_blocked(input hss_pkg::hss_state_type s);
      return s.pause_on || s.disable_on ||
             (ext_reading(s.current_reading) >= hss_pkg::BAD_READING_LIMIT);
   endfunction

   // Set the reached latch when the reading is inside the band around target.
   function automatic hss_pkg::hss_state_type reach_update(input hss_pkg::hss_state_type s_in,
                                                            input hss_pkg::hss_cfg_type c);
      hss_pkg::hss_state_type s;
      logic signed [12:0]     cur;
      logic signed [12:0]     tv;
      logic signed [12:0]     h;
      s   = s_in;
      cur = ext_reading(s.current_reading);
      tv  = ext_target(s.target_value);
      h   = $signed({8'd0, c.reach_hysteresis});
      if (!reach_blocked(s) && !s.reached_latch && (cur >= tv - h) && (cur <= tv + h)) begin
         s.reached_latch = 1'b1;
      end
      return s;
   endfunction

   function automatic hss_pkg::hss_state_type do_fail(input hss_pkg::hss_state_type s_in,
                                                       input hss_pkg::hss_cfg_type c,
                                                       input logic [1:0] code);
      hss_pkg::hss_state_type s;
      s               = s_in;
      s.fault_code    = code;
      s.fault_latched = 1'b1;
      s               = set_target(s, c, 16'sd0);
      s.last_power    = '0;
      return s;
   endfunction

   // Count a bad event; the heater fails once the run passes the limit.
   function automatic hss_pkg::hss_state_type bad_event(input hss_pkg::hss_state_type s_in,
                                                         input hss_pkg::hss_cfg_type c,
                                                         input logic [1:0] code);
      hss_pkg::hss_state_type s;
      s = s_in;
      if (s.bad_run_count != hss_pkg::RUN_COUNT_MAX) s.bad_run_count = s.bad_run_count + 8'd1;
      if (s.bad_run_count > c.max_bad_readings) s = do_fail(s, c, code);
      return s;
   endfunction

   function automatic hss_pkg::hss_state_type do_sample(input hss_pkg::hss_state_type s_in,
                                                         input hss_pkg::hss_cfg_type c,
                                                         input hss_pkg::hss_req_type it);
      hss_pkg::hss_state_type s;
      logic                   bad;
      logic                   reached;
      logic signed [12:0]     temp;
      logic signed [12:0]     tv;
      logic signed [12:0]     delta;
      logic signed [12:0]     band;
      s    = s_in;
      bad  = 1'b0;
      temp = ext_reading(it.temperature);
      if (s.disable_on) return s;
      s.current_reading = it.temperature;
      if (s.heatup_armed) s.heatup_remaining = count_down(s.heatup_remaining, it.elapsed_ms);
      if (s.progress_armed) begin
         s.progress_remaining = count_down(s.progress_remaining, it.elapsed_ms);
      end
      // Fault checks run only while not paused.
      if (!s.pause_on) begin
         if (temp > ext_target(c.cutoff_temp)) begin
            bad = 1'b1;
            s   = bad_event(s, c, hss_pkg::FAIL_CUTOFF);
            if (s.bad_run_count > c.max_bad_readings) return s;
         end
         if (!s.progress_done && s.progress_armed && (s.progress_remaining == '0)) begin
            if (temp < ext_reading(s.start_reading) + hss_pkg::PROGRESS_STEP) begin
               bad = 1'b1;
               s   = bad_event(s, c, hss_pkg::FAIL_NOT_HEATING);
               if (s.bad_run_count > c.max_bad_readings) return s;
            end else begin
               s.progress_done = 1'b1;
            end
         end
         if (s.heatup_armed && (s.heatup_remaining == '0)) begin
            s       = reach_update(s, c);
            reached = !reach_blocked(s) && s.reached_latch;
            if (reached && (temp < ext_target(s.target_value) - hss_pkg::DROP_MARGIN)) begin
               bad = 1'b1;
               s   = bad_event(s, c, hss_pkg::FAIL_DROPPING);
               if (s.bad_run_count > c.max_bad_readings) return s;
            end
         end
         if (!bad) s.bad_run_count = '0;
      end
      if (s.fault_latched) return s;
      // Full-power bypass with hysteresis on the shortfall below target.
      tv    = ext_target(s.target_value);
      delta = tv - temp;
      band  = $signed({5'd0, c.bypass_delta});
      if (s.bypass_on && (delta < band)) begin
         s.bypass_on = 1'b0;
         s.pid_pulse = 1'b1;
      end else if (!s.bypass_on && (delta > band + hss_pkg::BYPASS_BAND)) begin
         s.bypass_on = 1'b1;
      end
      if (s.bypass_on) begin
         s.last_power = hss_pkg::POWER_FULL;
      end else if (s.target_value != '0) begin
         if (it.pid_drive[15]) begin
            s.last_power = '0;
         end else if (it.pid_drive[14:8] != '0) begin
            s.last_power = hss_pkg::POWER_FULL;
         end else begin
            s.last_power = it.pid_drive[7:0];
         end
      end else begin
         s.last_power = '0;
      end
      return s;
   endfunction

   // Pause holds the current reading as target, but only while heating.
   function automatic hss_pkg::hss_state_type do_pause(input hss_pkg::hss_state_type s_in,
                                                        input hss_pkg::hss_cfg_type c);
      hss_pkg::hss_state_type s;
      logic                   heating;
      logic signed [15:0]     hold;
      s = s_in;
      if (s.disable_on || s.pause_on) return s;
      if (s.target_value == '0) begin
         heating = 1'b0;
      end else begin
         s       = reach_update(s, c);
         heating = !(!reach_blocked(s) && s.reached_latch) && !s.fault_latched;
      end
      if (!heating) return s;
      s.saved_target = s.target_value;
      if (ext_reading(s.current_reading) < hss_pkg::BAD_READING_LIMIT) begin
         hold = $signed({{5{s.current_reading[10]}}, s.current_reading});
      end else begin
         hold = 16'sd0;
      end
      s                    = set_target(s, c, hold);
      s.heatup_armed       = 1'b0;
      s.heatup_remaining   = '0;
      s.progress_armed     = 1'b0;
      s.progress_remaining = '0;
      s.reached_latch      = 1'b0;
      s.pause_on           = 1'b1;
      return s;
   endfunction

   function automatic hss_pkg::hss_state_type do_resume(input hss_pkg::hss_state_type s_in,
                                                         input hss_pkg::hss_cfg_type c);
      hss_pkg::hss_state_type s;
      s = s_in;
      if (s.disable_on || !s.pause_on) return s;
      s.pause_on = 1'b0;
      return set_target(s, c, $signed({6'd0, s.saved_target}));
   endfunction

   // Clear everything but the power level and ask the PID to reset.
   function automatic hss_pkg::hss_state_type clear_all(input hss_pkg::hss_state_type s_in);
      hss_pkg::hss_state_type s;
      s            = '0;
      s.last_power = s_in.last_power;
      s.pid_pulse  = 1'b1;
      return s;
   endfunction

   // One item applied to the current state.
   always_comb begin
      step_state           = state_ff;
      step_state.pid_pulse = 1'b0;
      case (item.cmd)
         hss_pkg::CMD_SAMPLE:     step_state = do_sample(step_state, cfg, item);
         hss_pkg::CMD_SET_TARGET: step_state = set_target(step_state, cfg,
                                                          $signed(item.new_target));
         hss_pkg::CMD_PAUSE:      step_state = do_pause(step_state, cfg);
         hss_pkg::CMD_RESUME:     step_state = do_resume(step_state, cfg);
         hss_pkg::CMD_DISABLE: begin
            step_state            = clear_all(step_state);
            step_state.disable_on = 1'b1;
         end
         hss_pkg::CMD_ENABLE:     step_state.disable_on = 1'b0;
         hss_pkg::CMD_RESET:      step_state = clear_all(step_state);
         default:                 step_state = step_state;
      endcase
   end

   assign state_in = fire ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // Status after the item, loaded into the response register by the top level.
   always_comb begin
      rsp.heater_power   = step_state.last_power;
      rsp.bypass_active  = step_state.bypass_on;
      rsp.pid_clear      = step_state.pid_pulse;
      rsp.failed         = step_state.fault_latched;
      rsp.fail_reason    = step_state.fault_code;
      rsp.target_reached = step_state.reached_latch;
      rsp.active_target  = step_state.target_value;
      rsp.paused_flag    = step_state.pause_on;
      rsp.disabled_flag  = step_state.disable_on;
   end

endmodule

// ===== hw/rtl/heater_safety_supervisor.sv =====
// Heater safety supervisor for one heating element. Each request transfer carries a
// command (sample, set target, pause, resume, disable, enable, reset) and gives exactly
// one response transfer with the status after it: heater power, bypass and fault flags,
// the reached flag and the active target. The block sustains one request per clock
// cycle while the response channel is not stalled; a request transfer loads the input
// register, and the item's response is loaded into the response register when that
// register is empty or being taken. The whole state update for an item is a
// combinational loop from the state registers back to themselves. A waiting response
// does not stop the next request from entering an empty input register. Configuration
// must be written through the APB-style csr_ port only while no item is in flight; the
// block itself does not enforce it. There is no clearing pass after reset.
// Depends on hss_pkg, hss_channels, hss_csr and hss_core.
`timescale 1ns / 1ps

module heater_safety_supervisor (
   input  logic                           clock,
   input  logic                           reset,
   hss_req_if.sink                        req_ch,
   hss_rsp_if.source                      rsp_ch,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [hss_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [hss_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [hss_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   hss_pkg::hss_cfg_type cfg;
   hss_pkg::hss_req_type req_item;
   hss_pkg::hss_req_type in_item_ff;
   hss_pkg::hss_rsp_type step_rsp;
   hss_pkg::hss_rsp_type rsp_data_ff;
   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 advance;
   logic                 fire;
   logic                 take;

   hss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // The pipeline moves when the response register is empty or being taken.
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_ch.ready ? req_ch.valid : in_valid_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_comb begin
      req_item.cmd         = req_ch.cmd;
      req_item.temperature = req_ch.temperature;
      req_item.pid_drive   = req_ch.pid_drive;
      req_item.elapsed_ms  = req_ch.elapsed_ms;
      req_item.new_target  = req_ch.new_target;
   end

   hss_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_item_ff),
      .cfg   (cfg),
      .rsp   (step_rsp)
   );

   // Valid flags of the input and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load on a transfer into their stage.
   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff <= req_item;
      end
      if (fire) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.heater_power   = rsp_data_ff.heater_power;
   assign rsp_ch.bypass_active  = rsp_data_ff.bypass_active;
   assign rsp_ch.pid_clear      = rsp_data_ff.pid_clear;
   assign rsp_ch.failed         = rsp_data_ff.failed;
   assign rsp_ch.fail_reason    = rsp_data_ff.fail_reason;
   assign rsp_ch.target_reached = rsp_data_ff.target_reached;
   assign rsp_ch.active_target  = rsp_data_ff.active_target;
   assign rsp_ch.paused_flag    = rsp_data_ff.paused_flag;
   assign rsp_ch.disabled_flag  = rsp_data_ff.disabled_flag;

endmodule

// ===== hw/rtl/hss_checker.sv =====
// Port-level checks on the response channel of the heater safety supervisor,
// attached to the top level by the bind statement at the end. Depends on hss_pkg.
`timescale 1ns / 1ps

module hss_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] heater_power,
   input logic       bypass_active,
   input logic       failed,
   input logic [1:0] fail_reason,
   input logic       target_reached,
   input logic [9:0] active_target,
   input logic       paused_flag,
   input logic       disabled_flag
);

   // A stalled response stays valid and keeps its power, target and fail reason.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(heater_power) &&
      $stable(active_target) && $stable(fail_reason))
      else $error("response changed while stalled");

   // A failed heater is off and reports a reason.
   a_fail_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && failed |-> heater_power == 8'd0 && fail_reason != hss_pkg::FAIL_NONE)
      else $error("failed heater still driven or without reason");

   // Bypass means full power unless the heater failed.
   a_bypass_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && bypass_active && !failed |-> heater_power == hss_pkg::POWER_FULL)
      else $error("bypass active without full power");

   // A disabled heater has no target, fault, pause, bypass or reached flag.
   a_disabled_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && disabled_flag |-> !failed && !paused_flag && !bypass_active &&
      !target_reached && active_target == 10'd0)
      else $error("disabled heater shows active state");

endmodule

bind heater_safety_supervisor hss_checker u_hss_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .heater_power   (rsp_ch.heater_power),
   .bypass_active  (rsp_ch.bypass_active),
   .failed         (rsp_ch.failed),
   .fail_reason    (rsp_ch.fail_reason),
   .target_reached (rsp_ch.target_reached),
   .active_target  (rsp_ch.active_target),
   .paused_flag    (rsp_ch.paused_flag),
   .disabled_flag  (rsp_ch.disabled_flag)
);
